FILE: design/sis_pkg.sv
`timescale 1ns / 1ps
// Package for the sorted interval set: per-cell command codes and beat types.
// No dependencies.
package sis_pkg;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EVAL,
        ST_APPLY,
        ST_DONE
    } t_state;

    typedef enum logic [1:0] {
        OP_HOLD,
        OP_WRITE,
        OP_SHIFT_UP,
        OP_SHIFT_DN
    } t_op;

    localparam logic REQ_ADD = 1'b0;
    localparam logic REQ_REMOVE = 1'b1;

endpackage

FILE: design/sorted_interval_set.sv
`timescale 1ns / 1ps
// Top level of the sorted interval set: control sequencer and the cell chain.
// Depends on sis_pkg and sis_cell.
//
// Usage: drive i_req_type, i_range_start and i_range_size with i_start high
// while o_busy is low; that edge accepts the request beat. Every cycle each
// cell compares its range with the request in parallel, then at most one cell
// is rewritten and the chain shifts by at most one place (merge, insert,
// split, trim, delete). The result beat is on o_changed, o_error_code and
// o_range_count for exactly one cycle with o_done high. An empty request goes
// straight to the done state; any other passes through the evaluate state, a
// split or a merge then through the apply state, which a merge repeats once
// per absorbed range, and other removes stay in evaluate once more for each
// trimmed or deleted range. o_busy stays high while o_done is high, so a new
// beat is accepted only once the block is idle again. The receiver cannot
// stall, so nothing waits. After reset the set is empty and the block is idle;
// the cells need no clearing pass since each carries its own valid flag.
module sorted_interval_set #(
    parameter int MAX_RANGES  = 16,
    parameter int VALUE_WIDTH = 16
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    output logic                         o_busy,
    input  logic                         i_req_type,
    input  logic [15:0]                  i_range_start,
    input  logic [16:0]                  i_range_size,
    output logic                         o_done,
    output logic                         o_changed,
    output logic                         o_error_code,
    output logic [4:0]                   o_range_count
);

    localparam int N  = MAX_RANGES;
    localparam int CW = $clog2(N + 1);
    localparam int IW = (N > 1) ? $clog2(N) : 1;
    localparam int VW = VALUE_WIDTH;
    localparam int XW = (VW + 2 > 18) ? VW + 2 : 18;
    localparam logic [XW-1:0] TOP = XW'({VW{1'b1}});

    sis_pkg::t_state r_state, n_state;
    logic             r_type, n_type;
    logic [VW-1:0]    r_s, n_s;
    logic [VW-1:0]    r_l, n_l;
    logic             r_changed, n_changed;
    logic             r_err, n_err;
    logic [CW-1:0]    r_count, n_count;
    logic [IW-1:0]    r_pos, n_pos;

    logic [VW-1:0]    c_first [N];
    logic [VW-1:0]    c_last  [N];
    logic             c_valid [N];
    logic [VW-1:0]    w_first, w_last;

    // Per-cell comparisons, all in parallel.
    logic [N-1:0] m_reach, m_above, m_cover, m_inside, m_trim_r, m_trim_l;

    logic [XW-1:0] w_sx, w_sum, w_lx;

    always_comb begin
        w_sx  = (XW'(i_range_start) > TOP) ? TOP : XW'(i_range_start);
        w_sum = w_sx + XW'(i_range_size) - XW'(1);
        w_lx  = (w_sum > TOP) ? TOP : w_sum;
    end

    for (genvar g = 0; g < N; g++) begin : g_cmp
        logic [VW:0] cf, cl, s, l;
        assign cf = {1'b0, c_first[g]};
        assign cl = {1'b0, c_last[g]};
        assign s  = {1'b0, r_s};
        assign l  = {1'b0, r_l};
        assign m_reach[g]  = c_valid[g] &&
            ((s >= cf && s <= cl + 1'b1) || (cf >= s && cf <= l + 1'b1));
        assign m_above[g]  = c_valid[g] && (s < cf);
        assign m_cover[g]  = c_valid[g] && s <= cf && l >= cl;
        assign m_inside[g] = c_valid[g] && s > cf && l < cl;
        assign m_trim_r[g] = c_valid[g] && s > cf && s <= cl && l >= cl;
        assign m_trim_l[g] = c_valid[g] && s <= cf && l >= cf && l < cl;
    end

    // Lowest index with a set bit, as a short priority search.
    function automatic logic [IW-1:0] first_set(input logic [N-1:0] v);
        logic [IW-1:0] r;
        r = '0;
        for (int k = N - 1; k >= 0; k--) begin
            if (v[k]) begin
                r = IW'(k);
            end
        end
        return r;
    endfunction

    logic [IW-1:0] p_reach, p_above, p_cover, p_inside, p_trl, p_trr;
    assign p_reach  = first_set(m_reach);
    assign p_above  = first_set(m_above);
    assign p_cover  = first_set(m_cover);
    assign p_inside = first_set(m_inside);
    assign p_trl    = first_set(m_trim_l);
    assign p_trr    = first_set(m_trim_r);

    logic [VW-1:0]  rc_first, rc_last;
    logic [IW-1:0]  ins_pos;
    assign rc_first = c_first[p_reach];
    assign rc_last  = c_last[p_reach];
    assign ins_pos  = (|m_above) ? p_above : r_count[IW-1:0];

    // Neighbor after the merged cell, for absorption and for the split tail.
    logic           nx_ok;
    logic [IW-1:0]  nx_pos;
    always_comb begin
        nx_pos = r_pos + 1'b1;
        nx_ok  = (32'(r_pos) < N - 1) && c_valid[nx_pos] &&
                 ({1'b0, c_first[nx_pos]} <= {1'b0, c_last[r_pos]} + 1'b1);
    end

    // Chain action this step: at most one write and at most one shift.
    logic          sh_up, sh_dn;
    logic [IW-1:0] sh_pos, wr_pos;
    logic          wr_en;

    always_comb begin
        n_state   = r_state;
        n_changed = r_changed;
        n_err     = r_err;
        n_count   = r_count;
        n_s       = r_s;
        n_l       = r_l;
        n_type    = r_type;
        n_pos     = r_pos;
        sh_up     = 1'b0;
        sh_dn     = 1'b0;
        sh_pos    = '0;
        wr_en     = 1'b0;
        wr_pos    = '0;
        w_first   = r_s;
        w_last    = r_l;
        case (r_state)
            sis_pkg::ST_IDLE: begin
                if (i_start) begin
                    n_s       = w_sx[VW-1:0];
                    n_l       = w_lx[VW-1:0];
                    n_type    = i_req_type;
                    n_changed = 1'b0;
                    n_err     = 1'b0;
                    n_state   = (i_range_size == '0) ? sis_pkg::ST_DONE : sis_pkg::ST_EVAL;
                end
            end
            sis_pkg::ST_EVAL: begin
                if (r_type == sis_pkg::REQ_ADD) begin
                    if (|m_reach) begin
                        wr_en     = 1'b1;
                        wr_pos    = p_reach;
                        w_first   = (r_s < rc_first) ? r_s : rc_first;
                        w_last    = (r_l > rc_last) ? r_l : rc_last;
                        n_pos     = p_reach;
                        n_changed = 1'b1;
                        n_state   = sis_pkg::ST_APPLY;
                    end else if (r_count >= CW'(N)) begin
                        n_err   = 1'b1;
                        n_state = sis_pkg::ST_DONE;
                    end else begin
                        wr_en     = 1'b1;
                        wr_pos    = ins_pos;
                        sh_up     = 1'b1;
                        sh_pos    = ins_pos;
                        n_count   = r_count + 1'b1;
                        n_changed = 1'b1;
                        n_state   = sis_pkg::ST_DONE;
                    end
                end else begin
                    if (|m_inside) begin
                        if (r_count >= CW'(N)) begin
                            n_err   = 1'b1;
                            n_state = sis_pkg::ST_DONE;
                        end else begin
                            wr_en     = 1'b1;
                            wr_pos    = p_inside;
                            w_first   = c_first[p_inside];
                            w_last    = r_s - 1'b1;
                            sh_up     = 1'b1;
                            sh_pos    = p_inside;
                            n_pos     = p_inside;
                            n_count   = r_count + 1'b1;
                            n_changed = 1'b1;
                            n_state   = sis_pkg::ST_APPLY;
                        end
                    end else if (|m_cover) begin
                        sh_dn     = 1'b1;
                        sh_pos    = p_cover;
                        n_count   = r_count - 1'b1;
                        n_changed = 1'b1;
                    end else if (|m_trim_r) begin
                        wr_en     = 1'b1;
                        wr_pos    = p_trr;
                        w_first   = c_first[p_trr];
                        w_last    = r_s - 1'b1;
                        n_changed = 1'b1;
                    end else if (|m_trim_l) begin
                        wr_en     = 1'b1;
                        wr_pos    = p_trl;
                        w_first   = r_l + 1'b1;
                        w_last    = c_last[p_trl];
                        n_changed = 1'b1;
                    end else begin
                        n_state = sis_pkg::ST_DONE;
                    end
                end
            end
            sis_pkg::ST_APPLY: begin
                if (r_type == sis_pkg::REQ_ADD) begin
                    if (nx_ok) begin
                        wr_en   = 1'b1;
                        wr_pos  = r_pos;
                        w_first = c_first[r_pos];
                        w_last  = (c_last[nx_pos] > c_last[r_pos]) ?
                                  c_last[nx_pos] : c_last[r_pos];
                        sh_dn   = 1'b1;
                        sh_pos  = nx_pos;
                        n_count = r_count - 1'b1;
                    end else begin
                        n_state = sis_pkg::ST_DONE;
                    end
                end else begin
                    // The upper half of a split range.
                    wr_en   = 1'b1;
                    wr_pos  = nx_pos;
                    w_first = r_l + 1'b1;
                    w_last  = c_last[nx_pos];
                    n_state = sis_pkg::ST_DONE;
                end
            end
            sis_pkg::ST_DONE: begin
                n_state = sis_pkg::ST_IDLE;
            end
            default: begin
                n_state = sis_pkg::ST_IDLE;
            end
        endcase
    end

    for (genvar g = 0; g < N; g++) begin : g_chain
        logic [IW-1:0] gi;
        sis_pkg::t_op  op;
        assign gi = IW'(g);
        always_comb begin
            op = sis_pkg::OP_HOLD;
            if (wr_en && gi == wr_pos) begin
                op = sis_pkg::OP_WRITE;
            end else if (sh_up && gi > sh_pos) begin
                op = sis_pkg::OP_SHIFT_UP;
            end else if (sh_dn && gi >= sh_pos) begin
                op = sis_pkg::OP_SHIFT_DN;
            end
        end
        if (g == 0) begin : g_head
            sis_cell #(.VALUE_WIDTH(VW)) u_cell (
                .i_clk(i_clk), .i_rst_n(i_rst_n), .i_op(op),
                .i_wr_valid(1'b1), .i_wr_first(w_first), .i_wr_last(w_last),
                .i_lo_valid(1'b0), .i_lo_first(c_first[g]), .i_lo_last(c_last[g]),
                .i_hi_valid(c_valid[g+1]),
                .i_hi_first(c_first[g+1]), .i_hi_last(c_last[g+1]),
                .o_valid(c_valid[g]), .o_first(c_first[g]), .o_last(c_last[g])
            );
        end else if (g == N - 1) begin : g_tail
            sis_cell #(.VALUE_WIDTH(VW)) u_cell (
                .i_clk(i_clk), .i_rst_n(i_rst_n), .i_op(op),
                .i_wr_valid(1'b1), .i_wr_first(w_first), .i_wr_last(w_last),
                .i_lo_valid(c_valid[g-1]), .i_lo_first(c_first[g-1]),
                .i_lo_last(c_last[g-1]),
                .i_hi_valid(1'b0), .i_hi_first(c_first[g]), .i_hi_last(c_last[g]),
                .o_valid(c_valid[g]), .o_first(c_first[g]), .o_last(c_last[g])
            );
        end else begin : g_mid
            sis_cell #(.VALUE_WIDTH(VW)) u_cell (
                .i_clk(i_clk), .i_rst_n(i_rst_n), .i_op(op),
                .i_wr_valid(1'b1), .i_wr_first(w_first), .i_wr_last(w_last),
                .i_lo_valid(c_valid[g-1]), .i_lo_first(c_first[g-1]),
                .i_lo_last(c_last[g-1]),
                .i_hi_valid(c_valid[g+1]), .i_hi_first(c_first[g+1]),
                .i_hi_last(c_last[g+1]),
                .o_valid(c_valid[g]), .o_first(c_first[g]), .o_last(c_last[g])
            );
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= sis_pkg::ST_IDLE;
            r_count   <= '0;
            r_changed <= 1'b0;
            r_err     <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_count   <= n_count;
            r_changed <= n_changed;
            r_err     <= n_err;
        end
        r_s    <= n_s;
        r_l    <= n_l;
        r_type <= n_type;
        r_pos  <= n_pos;
    end

    assign o_busy        = (r_state != sis_pkg::ST_IDLE);
    assign o_done        = (r_state == sis_pkg::ST_DONE);
    assign o_changed     = r_changed;
    assign o_error_code  = r_err;
    assign o_range_count = 5'(r_count);

    assert property (@(posedge i_clk) disable iff (!i_rst_n) o_done |=> !o_busy)
        else $error("done not followed by idle");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
                     o_done |-> !(o_changed && o_error_code))
        else $error("refused request reported as changed");
    assert property (@(posedge i_clk) disable iff (!i_rst_n) r_count <= CW'(N))
        else $error("range count beyond capacity");

endmodule

FILE: design/sis_cell.sv
`timescale 1ns / 1ps
// One storage cell of the interval chain: holds one range and its valid flag.
// Depends on sis_pkg.
module sis_cell #(
    parameter int VALUE_WIDTH = 16
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  sis_pkg::t_op           i_op,
    input  logic                   i_wr_valid,
    input  logic [VALUE_WIDTH-1:0] i_wr_first,
    input  logic [VALUE_WIDTH-1:0] i_wr_last,
    input  logic                   i_lo_valid,
    input  logic [VALUE_WIDTH-1:0] i_lo_first,
    input  logic [VALUE_WIDTH-1:0] i_lo_last,
    input  logic                   i_hi_valid,
    input  logic [VALUE_WIDTH-1:0] i_hi_first,
    input  logic [VALUE_WIDTH-1:0] i_hi_last,
    output logic                   o_valid,
    output logic [VALUE_WIDTH-1:0] o_first,
    output logic [VALUE_WIDTH-1:0] o_last
);

    logic                   r_valid;
    logic [VALUE_WIDTH-1:0] r_first;
    logic [VALUE_WIDTH-1:0] r_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            case (i_op)
                sis_pkg::OP_WRITE: begin
                    r_valid <= i_wr_valid;
                    r_first <= i_wr_first;
                    r_last  <= i_wr_last;
                end
                sis_pkg::OP_SHIFT_UP: begin
                    r_valid <= i_lo_valid;
                    r_first <= i_lo_first;
                    r_last  <= i_lo_last;
                end
                sis_pkg::OP_SHIFT_DN: begin
                    r_valid <= i_hi_valid;
                    r_first <= i_hi_first;
                    r_last  <= i_hi_last;
                end
                default: begin
                end
            endcase
        end
    end

    assign o_valid = r_valid;
    assign o_first = r_first;
    assign o_last  = r_last;

endmodule

FILE: sim/tb_sorted_interval_set.sv
`timescale 1ns / 1ps
// Self-checking testbench for sorted_interval_set: directed table, then random add/remove beats.
// Depends on sis_pkg and the sorted_interval_set RTL.
module tb_sorted_interval_set;

    localparam int SLOTS = 16;
    localparam int TOP = 65535;
    localparam int N_RANDOM = 1630;
    localparam int CYCLE_LIMIT = 400000;
    localparam logic EXP_ANY = 1'b0;
    localparam logic EXP_FIXED = 1'b1;

    typedef struct packed {
        logic        changed;
        logic        err;
        logic [4:0]  count;
    } t_outcome;

    typedef struct {
        logic        kind;
        logic [15:0] base;
        logic [16:0] span;
        logic        fixed;
        t_outcome    want;
    } t_row;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_start;
    logic        o_busy;
    logic        i_req_type;
    logic [15:0] i_range_start;
    logic [16:0] i_range_size;
    logic        o_done;
    logic        o_changed;
    logic        o_error_code;
    logic [4:0]  o_range_count;

    int          set_lo[SLOTS + 1];
    int          set_hi[SLOTS + 1];
    int          set_n;
    t_outcome    pending_outcomes[$];
    int          mismatches;
    int          cycles;
    bit          quiet_sender;
    t_row        rows[$];

    sorted_interval_set uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(i_start), .o_busy(o_busy),
        .i_req_type(i_req_type), .i_range_start(i_range_start),
        .i_range_size(i_range_size), .o_done(o_done), .o_changed(o_changed),
        .o_error_code(o_error_code), .o_range_count(o_range_count)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    function automatic bit touches(int af, int al, int bf, int bl);
        return (bf >= af && bf <= al + 1) || (af >= bf && af <= bl + 1);
    endfunction

    function automatic void shift_up(int pos);
        for (int k = set_n; k > pos; k--) begin
            set_lo[k] = set_lo[k - 1];
            set_hi[k] = set_hi[k - 1];
        end
        set_n++;
    endfunction

    function automatic int merge_range(int s, int l);
        int i;
        int j;
        int gone;
        for (i = 0; i < set_n; i++) begin
            if (touches(set_lo[i], set_hi[i], s, l)) begin
                if (s < set_lo[i]) set_lo[i] = s;
                if (l > set_hi[i]) set_hi[i] = l;
                j = i + 1;
                while (j < set_n && touches(set_lo[i], set_hi[i], set_lo[j], set_hi[j])) begin
                    if (set_lo[j] < set_lo[i]) set_lo[i] = set_lo[j];
                    if (set_hi[j] > set_hi[i]) set_hi[i] = set_hi[j];
                    j++;
                end
                gone = j - i - 1;
                for (int k = j; k < set_n; k++) begin
                    set_lo[k - gone] = set_lo[k];
                    set_hi[k - gone] = set_hi[k];
                end
                set_n -= gone;
                return 1;
            end
            if (s < set_lo[i]) break;
        end
        if (set_n >= SLOTS) return 2;
        shift_up(i);
        set_lo[i] = s;
        set_hi[i] = l;
        return 1;
    endfunction

    function automatic int cut_range(int s, int l);
        bit keep[SLOTS + 1];
        bit hit;
        int n;
        int cf;
        int cl;
        hit = 1'b0;
        for (int i = 0; i < set_n; i++) begin
            cf = set_lo[i];
            cl = set_hi[i];
            keep[i] = 1'b1;
            if (s > cf) begin
                if (l < cl) begin
                    if (set_n >= SLOTS) return 2;
                    shift_up(i);
                    set_lo[i] = cf;
                    set_hi[i] = s - 1;
                    set_lo[i + 1] = l + 1;
                    set_hi[i + 1] = cl;
                    return 1;
                end else if (s <= cl) begin
                    set_hi[i] = s - 1;
                    hit = 1'b1;
                end
            end else if (l >= cf) begin
                if (l >= cl) keep[i] = 1'b0;
                else set_lo[i] = l + 1;
                hit = 1'b1;
            end
        end
        n = 0;
        for (int i = 0; i < set_n; i++) begin
            if (keep[i]) begin
                set_lo[n] = set_lo[i];
                set_hi[n] = set_hi[i];
                n++;
            end
        end
        set_n = n;
        return hit ? 1 : 0;
    endfunction

    function automatic t_outcome apply_request(logic kind, logic [15:0] base, logic [16:0] span);
        t_outcome o;
        int r;
        int l;
        r = 0;
        if (span != 0) begin
            l = int'(base) + int'(span) - 1;
            if (l > TOP) l = TOP;
            if (kind == sis_pkg::REQ_ADD) r = merge_range(int'(base), l);
            else if (set_n != 0) r = cut_range(int'(base), l);
        end
        o.changed = (r == 1);
        o.err = (r == 2);
        o.count = 5'(set_n);
        return o;
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        $display("MISMATCH %s: got %0d want %0d at cycle %0d", what, got, want, cycles);
        mismatches++;
    endtask

    always @(posedge i_clk) begin
        t_outcome w;
        cycles <= cycles + 1;
        if (i_rst_n && o_done) begin
            if (pending_outcomes.size() == 0) begin
                report_mismatch("unexpected beat", 1, 0);
            end else begin
                w = pending_outcomes.pop_front();
                if (o_changed !== w.changed) report_mismatch("changed", o_changed, w.changed);
                if (o_error_code !== w.err) report_mismatch("error_code", o_error_code, w.err);
                if (o_range_count !== w.count)
                    report_mismatch("range_count", o_range_count, w.count);
            end
        end
    end

    always @(posedge i_clk) begin
        if (cycles > CYCLE_LIMIT) begin
            $display("sorted_interval_set verification failed");
            $finish;
        end
    end

    task automatic send(logic kind, logic [15:0] base, logic [16:0] span, logic fixed,
                        t_outcome want);
        t_outcome p;
        int gap;
        if (!quiet_sender && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 12);
            i_start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_req_type <= kind;
        i_range_start <= base;
        i_range_size <= span;
        i_start <= 1'b1;
        @(posedge i_clk);
        while (o_busy) @(posedge i_clk);
        p = apply_request(kind, base, span);
        if (fixed && p !== want) report_mismatch("table row", int'(p), int'(want));
        pending_outcomes.push_back(p);
    endtask

    task automatic add_row(logic kind, int base, int span, logic fixed, t_outcome want);
        t_row r;
        r.kind = kind;
        r.base = 16'(base);
        r.span = 17'(span);
        r.fixed = fixed;
        r.want = want;
        rows.push_back(r);
    endtask

    function automatic logic [16:0] pick_span();
        case ($urandom_range(0, 9))
            0: return 17'd0;
            1: return 17'd65536;
            2: return 17'($urandom_range(0, 131071));
            3, 4: return 17'($urandom_range(1, 4000));
            default: return 17'($urandom_range(1, 40));
        endcase
    endfunction

    function automatic logic [15:0] pick_base();
        case ($urandom_range(0, 9))
            0: return 16'($urandom_range(0, 65535));
            1: return 16'($urandom_range(65500, 65535));
            2: return 16'($urandom_range(0, 40));
            default: return 16'($urandom_range(0, 600));
        endcase
    endfunction

    initial begin
        t_outcome none;
        none = '0;
        i_rst_n = 1'b0;
        i_start = 1'b0;
        i_req_type = sis_pkg::REQ_ADD;
        i_range_start = '0;
        i_range_size = '0;
        set_n = 0;
        mismatches = 0;
        cycles = 0;
        quiet_sender = 1'b0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        add_row(sis_pkg::REQ_REMOVE, 10, 5, EXP_FIXED, '{1'b0, 1'b0, 5'd0});
        add_row(sis_pkg::REQ_ADD, 10, 0, EXP_FIXED, '{1'b0, 1'b0, 5'd0});
        add_row(sis_pkg::REQ_ADD, 65535, 65536, EXP_FIXED, '{1'b1, 1'b0, 5'd1});
        add_row(sis_pkg::REQ_ADD, 0, 1, EXP_FIXED, '{1'b1, 1'b0, 5'd2});
        add_row(sis_pkg::REQ_ADD, 100, 10, EXP_ANY, none);
        add_row(sis_pkg::REQ_ADD, 110, 5, EXP_ANY, none);
        add_row(sis_pkg::REQ_ADD, 50, 5, EXP_ANY, none);
        add_row(sis_pkg::REQ_REMOVE, 102, 3, EXP_ANY, none);
        add_row(sis_pkg::REQ_REMOVE, 100, 1, EXP_ANY, none);
        add_row(sis_pkg::REQ_REMOVE, 112, 100, EXP_ANY, none);
        add_row(sis_pkg::REQ_REMOVE, 300, 10, EXP_ANY, none);
        add_row(sis_pkg::REQ_REMOVE, 50, 5, EXP_ANY, none);
        add_row(sis_pkg::REQ_ADD, 1, 200, EXP_ANY, none);
        add_row(sis_pkg::REQ_REMOVE, 0, 65536, EXP_FIXED, '{1'b1, 1'b0, 5'd0});
        for (int k = 0; k < 16; k++) add_row(sis_pkg::REQ_ADD, 1000 + 4 * k, 3, EXP_ANY, none);
        add_row(sis_pkg::REQ_ADD, 2000, 1, EXP_FIXED, '{1'b0, 1'b1, 5'd16});
        add_row(sis_pkg::REQ_REMOVE, 1001, 1, EXP_FIXED, '{1'b0, 1'b1, 5'd16});
        add_row(sis_pkg::REQ_ADD, 1002, 2, EXP_FIXED, '{1'b1, 1'b0, 5'd15});
        add_row(sis_pkg::REQ_REMOVE, 0, 65535, EXP_FIXED, '{1'b1, 1'b0, 5'd0});
        foreach (rows[r]) send(rows[r].kind, rows[r].base, rows[r].span, rows[r].fixed,
                               rows[r].want);

        for (int n = 0; n < N_RANDOM; n++) begin
            if (n == N_RANDOM / 2) begin
                i_start <= 1'b0;
                while (pending_outcomes.size() != 0) @(posedge i_clk);
            end
            if (n == N_RANDOM - 200) quiet_sender = 1'b1;
            send(($urandom_range(0, 9) < (set_n > 12 ? 6 : 4)) ?
                 sis_pkg::REQ_REMOVE : sis_pkg::REQ_ADD,
                 pick_base(), pick_span(), EXP_ANY, none);
        end
        i_start <= 1'b0;
        while (pending_outcomes.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("sorted_interval_set verification clean");
        end else begin
            $display("sorted_interval_set verification failed");
        end
        $finish;
    end
endmodule

FILE: filelist.f
design/sis_pkg.sv
design/sis_cell.sv
design/sorted_interval_set.sv
sim/tb_sorted_interval_set.sv
